[rtl/linear_scan_max_priority_queue_defines.svh]
// ----------------------------------------------------------------------------
// Linear scan max priority queue - assertion macros
// Shared concurrent assertion wrappers for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define LINEAR_SCAN_MAX_PRIORITY_QUEUE_DEFINES_SVH

// check on every clock edge outside reset
`define LSMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define LSMPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/lsmpq_pkg.sv]
// ----------------------------------------------------------------------------
// Linear scan max priority queue - package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsmpq_pkg;

  localparam int DEPTH      = 128;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int COUNT_W    = 8;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = VAL_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = VAL_W + COUNT_W;
  localparam int OUT_USER_W = 1 + STAT_W;

  localparam logic signed [VAL_W-1:0] EMPTY_SENTINEL = -32'sd987987987;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } lsmpq_op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } lsmpq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } lsmpq_state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic scan_step;
    logic scan_finish;
    logic out_load;
  } lsmpq_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic scan_done;
    logic out_free;
  } lsmpq_sts_t;

endpackage

[rtl/lsmpq_ctrl.sv]
// ----------------------------------------------------------------------------
// Linear scan max priority queue - controller
// Sequences accept, execute, scan/compact and result hand-off.
// ----------------------------------------------------------------------------
`include "linear_scan_max_priority_queue_defines.svh"

module lsmpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  lsmpq_pkg::lsmpq_sts_t sts_i,
  output lsmpq_pkg::lsmpq_cmd_t cmd_o
);
  import lsmpq_pkg::*;

  lsmpq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = (sts_i.is_pop && !sts_i.empty) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load_in   = s_axis_tvalid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_finish = sts_i.scan_done;
        cmd_o.scan_step   = !sts_i.scan_done;
      end
      ST_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `LSMPQ_ASSERT(a_accept_to_exec, s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_EXEC, "accepted word not executed")
  `LSMPQ_ASSERT(a_scan_holds, state_q == ST_SCAN && !sts_i.scan_done |=> state_q == ST_SCAN, "scan left early")
  `LSMPQ_ASSERT(a_load_free, cmd_o.out_load |-> sts_i.out_free, "result loaded over pending word")

endmodule

[rtl/lsmpq_dp.sv]
// ----------------------------------------------------------------------------
// Linear scan max priority queue - datapath
// Entry memory, fill count, running maximum, scan/compact unit and
// result register.
// ----------------------------------------------------------------------------
`include "linear_scan_max_priority_queue_defines.svh"

module lsmpq_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lsmpq_pkg::lsmpq_cmd_t                  cmd_i,
  output lsmpq_pkg::lsmpq_sts_t                  sts_o,
  input  logic                                   in_opcode_i,
  input  logic signed [lsmpq_pkg::VAL_W-1:0]     in_value_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [lsmpq_pkg::VAL_W-1:0]     out_top_value_o,
  output logic                                   out_is_empty_o,
  output logic [lsmpq_pkg::COUNT_W-1:0]          out_entry_count_o,
  output logic [lsmpq_pkg::STAT_W-1:0]           out_status_o
);
  import lsmpq_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] mem_rdata_q;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata;

  lsmpq_op_e               op_q, op_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [VAL_W-1:0] top_q, top_d;
  lsmpq_status_e           status_q, status_d;
  logic [CNT_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]        proc_addr_q, proc_addr_d;
  logic                    found_q, found_d;
  logic                    have_max_q, have_max_d;
  logic signed [VAL_W-1:0] max_q, max_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_top_q;
  logic                    out_empty_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic [STAT_W-1:0]       out_status_q;
  logic                    issue;

  assign issue = rd_ptr_q < count_q;

  assign sts_o.is_pop    = (op_q == OP_POP);
  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_done = !issue && !rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    count_d     = count_q;
    top_d       = top_q;
    status_d    = status_q;
    rd_ptr_d    = rd_ptr_q;
    rd_vld_d    = rd_vld_q;
    proc_addr_d = proc_addr_q;
    found_d     = found_q;
    have_max_d  = have_max_q;
    max_d       = max_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IDX_W-1:0];
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q[IDX_W-1:0];

    if (cmd_i.load_in) begin
      op_d  = lsmpq_op_e'(in_opcode_i);
      val_d = in_value_i;
    end

    if (cmd_i.exec) begin
      rd_ptr_d   = '0;
      rd_vld_d   = 1'b0;
      found_d    = 1'b0;
      have_max_d = 1'b0;
      status_d   = STAT_OK;
      if (op_q == OP_PUSH) begin
        if (sts_o.full) begin
          status_d = STAT_FULL;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          if (sts_o.empty || val_q > top_q) top_d = val_q;
        end
      end else if (sts_o.empty) begin
        status_d = STAT_EMPTY;
      end
    end

    if (cmd_i.scan_step) begin
      mem_re      = issue;
      rd_vld_d    = issue;
      proc_addr_d = rd_ptr_q[IDX_W-1:0];
      if (issue) rd_ptr_d = rd_ptr_q + 1'b1;
      if (rd_vld_q) begin
        if (!found_q && mem_rdata_q == top_q) begin
          found_d = 1'b1;
        end else begin
          if (found_q) begin
            // shift down to close the gap
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(proc_addr_q - 1'b1);
            mem_wdata = mem_rdata_q;
          end
          have_max_d = 1'b1;
          if (!have_max_q || mem_rdata_q > max_q) max_d = mem_rdata_q;
        end
      end
    end

    if (cmd_i.scan_finish) begin
      count_d = count_q - 1'b1;
      top_d   = max_q;
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      have_max_q  <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_PUSH;
      status_q    <= STAT_OK;
    end else begin
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      have_max_q  <= have_max_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    top_q       <= top_d;
    proc_addr_q <= proc_addr_d;
    max_q       <= max_d;
    if (cmd_i.out_load) begin
      out_top_q    <= sts_o.empty ? EMPTY_SENTINEL : top_q;
      out_empty_q  <= sts_o.empty;
      out_count_q  <= COUNT_W'(count_q);
      out_status_q <= status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_top_value_o   = out_top_q;
  assign out_is_empty_o    = out_empty_q;
  assign out_entry_count_o = out_count_q;
  assign out_status_o      = out_status_q;

  `LSMPQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "fill count beyond depth")
  `LSMPQ_ASSERT(a_full_hold, cmd_i.exec && op_q == OP_PUSH && sts_o.full |=> $stable(count_q), "refused push changed count")
  `LSMPQ_ASSERT(a_shift_addr, cmd_i.scan_step && rd_vld_q && found_q |-> proc_addr_q != '0, "shift below first entry")
  `LSMPQ_ASSERT(a_top_found, cmd_i.scan_finish |-> found_q, "pop scan missed the top entry")

endmodule

[rtl/linear_scan_max_priority_queue.sv]
// Push, and any refused push or pop: accept, EXEC, then DONE loads the result word.
// Pop: accept, EXEC, SCAN, then DONE loads the result; one combined scan/compact pass
// over the stored entries through the single read port of the entry memory.
// One word in flight; the next is taken once the result is registered.
// Reset clears fill count and control; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// Linear scan max priority queue - top level
// Unsorted-array max priority queue with stream in/out ports.
// ----------------------------------------------------------------------------
module linear_scan_max_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] value
  input  logic [lsmpq_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [0] opcode
  input  logic [lsmpq_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [31:0] top_value, [39:32] entry_count
  output logic [lsmpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // [0] is_empty, [2:1] status
  output logic [lsmpq_pkg::OUT_USER_W-1:0]   m_axis_tuser_o
);
  import lsmpq_pkg::*;

  lsmpq_cmd_t              cmd;
  lsmpq_sts_t              sts;
  logic signed [VAL_W-1:0] top_value;
  logic                    is_empty;
  logic [COUNT_W-1:0]      entry_count;
  logic [STAT_W-1:0]       status;

  lsmpq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  lsmpq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_opcode_i       (s_axis_tuser_i[0]),
    .in_value_i        ($signed(s_axis_tdata_i[VAL_W-1:0])),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_top_value_o   (top_value),
    .out_is_empty_o    (is_empty),
    .out_entry_count_o (entry_count),
    .out_status_o      (status)
  );

  assign m_axis_tdata_o = {entry_count, top_value};
  assign m_axis_tuser_o = {status, is_empty};

endmodule

[dv/linear_scan_max_priority_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear scan max priority queue - stream testbench
// Drives push and pop words with random gaps, holds back the result side
// (including one long hold-off) and checks every result word against an
// unsorted-array queue model kept in a small scoreboard.
// ----------------------------------------------------------------------------
module linear_scan_max_priority_queue_test;
  import lsmpq_pkg::*;

  localparam int ITEMS       = 1560;
  localparam int IDLE_LIMIT  = 12000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic signed [VAL_W-1:0]   top;
    logic                      is_empty;
    logic [COUNT_W-1:0]        count;
    lsmpq_status_e             status;
  } queue_result_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} load_phase_e;

  class pq_scoreboard;
    logic signed [VAL_W-1:0] stored[$];
    queue_result_t           pending_q[$];
    int errors, n_results, n_push, n_pop, n_full, n_empty, peak;

    function int first_max_slot();
      int best;
      best = 0;
      for (int i = 1; i < stored.size(); i++)
        if (stored[i] > stored[best]) best = i;
      return best;
    endfunction

    function void note_word(lsmpq_op_e op, logic [VAL_W-1:0] value);
      queue_result_t exp;
      exp.status = STAT_OK;
      if (op == OP_PUSH) begin
        n_push++;
        if (stored.size() >= DEPTH) begin
          exp.status = STAT_FULL;
          n_full++;
        end else begin
          stored.push_back(value);
        end
      end else begin
        n_pop++;
        if (stored.size() == 0) begin
          exp.status = STAT_EMPTY;
          n_empty++;
        end else begin
          stored.delete(first_max_slot());
        end
      end
      if (stored.size() > peak) peak = stored.size();
      exp.top      = (stored.size() == 0) ? EMPTY_SENTINEL : stored[first_max_slot()];
      exp.is_empty = (stored.size() == 0);
      exp.count    = COUNT_W'(stored.size());
      pending_q.push_back(exp);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      queue_result_t exp;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing expected: top %0d count %0d",
                 $time, $signed(data[VAL_W-1:0]), data[OUT_DATA_W-1:VAL_W]);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (data[VAL_W-1:0] !== exp.top) begin
        $display("%0t: top_value expected %0d got %0d", $time, exp.top,
                 $signed(data[VAL_W-1:0]));
        errors++;
      end
      if (data[OUT_DATA_W-1:VAL_W] !== exp.count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, exp.count,
                 data[OUT_DATA_W-1:VAL_W]);
        errors++;
      end
      if (user[0] !== exp.is_empty) begin
        $display("%0t: is_empty expected %0b got %0b", $time, exp.is_empty, user[0]);
        errors++;
      end
      if (user[STAT_W:1] !== exp.status) begin
        $display("%0t: status expected %0d got %0d", $time, exp.status, user[STAT_W:1]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // [31:0] value
  logic [IN_USER_W-1:0]  s_axis_tuser_i;   // [0] opcode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // [31:0] top_value, [39:32] entry_count
  logic [OUT_USER_W-1:0] m_axis_tuser_o;   // [0] is_empty, [2:1] status

  pq_scoreboard sb;
  int           n_sent;
  int           burst_left;
  bit           quiet;
  int           idle_cycles;

  linear_scan_max_priority_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 15) - 8;
      6:          return EMPTY_SENTINEL + $urandom_range(0, 4) - 2;
      7:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    return $urandom_range(0, 1000) - 500;
    endcase
  endfunction

  task automatic send_word(input lsmpq_op_e op, input logic [VAL_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      quiet      = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(20, 80);
    end
    burst_left--;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(op, value);
    n_sent++;
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int  stall_left;
    bit  held_off;
    bit  sink_quiet;
    int  window;
    stall_left = 0;
    held_off   = 1'b0;
    sink_quiet = 1'b0;
    window     = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (window == 0) begin
        sink_quiet = ($urandom_range(0, 3) == 0);
        window     = $urandom_range(100, 400);
      end
      window--;
      if (!held_off && sb != null && sb.n_results >= 400) begin
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!sink_quiet && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_word(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("linear_scan_max_priority_queue test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    load_phase_e phase;
    int          mixed_left;
    int          push_pct;
    lsmpq_op_e   op;
    sb          = new();
    n_sent      = 0;
    burst_left  = 0;
    quiet       = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_PUSH;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pop, extremes, sentinel neighbours and ties
    send_word(OP_POP, 32'hffff_ffff);
    send_word(OP_PUSH, EMPTY_SENTINEL);
    send_word(OP_PUSH, EMPTY_SENTINEL - 1);
    send_word(OP_POP, '0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_PUSH, EMPTY_SENTINEL + 1);
    send_word(OP_PUSH, 32'h7fff_ffff);
    send_word(OP_PUSH, 32'd5);
    send_word(OP_PUSH, 32'd5);
    send_word(OP_PUSH, 32'hffff_ffff);
    send_word(OP_PUSH, 32'd0);
    send_word(OP_PUSH, 32'h7fff_ffff);
    repeat (9) send_word(OP_POP, 32'h5a5a_a5a5);
    send_word(OP_POP, '0);
    send_word(OP_PUSH, 32'h8000_0000);
    send_word(OP_POP, '0);

    phase      = PH_FILL;
    mixed_left = 0;
    while (n_sent < ITEMS) begin
      case (phase)
        PH_FILL: begin
          push_pct = 85;
          if (sb.stored.size() == DEPTH && $urandom_range(0, 2) == 0) phase = PH_DRAIN;
        end
        PH_DRAIN: begin
          push_pct = 15;
          if (sb.stored.size() == 0 && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 2) == 0) begin
              phase      = PH_MIXED;
              mixed_left = $urandom_range(40, 120);
            end else begin
              phase = PH_FILL;
            end
          end
        end
        default: begin
          push_pct = 50;
          mixed_left--;
          if (mixed_left <= 0) phase = PH_FILL;
        end
      endcase
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      send_word(op, (op == OP_POP) ? VAL_W'($urandom) : pick_value());
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d words: %0d pushes (%0d refused full), %0d pops (%0d refused empty)",
             n_sent, sb.n_push, sb.n_full, sb.n_pop, sb.n_empty);
    $display("Checked %0d result words, deepest fill %0d of %0d, %0d mismatches",
             sb.n_results, sb.peak, DEPTH, sb.errors);
    if (sb.errors == 0) begin
      $display("linear_scan_max_priority_queue test passed");
    end else begin
      $display("linear_scan_max_priority_queue test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lsmpq_pkg.sv
rtl/lsmpq_ctrl.sv
rtl/lsmpq_dp.sv
rtl/linear_scan_max_priority_queue.sv
dv/linear_scan_max_priority_queue_test.sv
